// ===== design/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// srp_pkg: storage read pacer shared definitions
// Register indexes, reset values and arithmetic constants of the pacer.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned TIME_W      = 63;
  localparam int unsigned PCT_W       = 9;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // configuration register indexes
  localparam cfg_index_t REG_ENABLED   = 3'd0;
  localparam cfg_index_t REG_BANDWIDTH = 3'd1;
  localparam cfg_index_t REG_BYPASS    = 3'd2;
  localparam cfg_index_t REG_BURST     = 3'd3;
  localparam cfg_index_t REG_FLIP_GAP  = 3'd4;

  // reset values
  localparam logic [14:0] BANDWIDTH_RST = 15'd100;
  localparam logic [29:0] BURST_RST     = 30'd5000000;
  localparam logic [31:0] FLIP_GAP_RST  = 32'd2000000000;

  // arithmetic constants
  localparam logic [29:0]       NS_PER_S   = 30'd1000000000;
  localparam int unsigned       MIB_SHIFT  = 20;
  localparam logic [PCT_W-1:0]  PCT_UNITY  = 9'd100;
  localparam logic [PCT_W-1:0]  PCT_MAX    = 9'd400;
  localparam logic [PCT_W-1:0]  ROUND_BIAS = 9'd12;
  localparam logic [30:0]       ROUND_STEP = 31'd25;
  localparam logic [30:0]       AVG_DIV    = 31'd10;
  localparam logic [30:0]       PCT_DIV    = 31'd100;
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

  // reciprocals 2^30 / d rounded up, exact for 23-bit dividends below d * 2^16
  localparam int unsigned       RECIP_SHIFT = 30;
  localparam logic [26:0]       RECIP_10    = 27'd107374183;
  localparam logic [26:0]       RECIP_25    = 27'd42949673;
  localparam logic [26:0]       RECIP_100   = 27'd10737419;

endpackage

// ===== design/storage_read_pacer_top.sv =====
// ----------------------------------------------------------------------------
// storage_read_pacer_top: paced disk read scheduler
// Charges read transfer times against a deadline cursor and tracks a frame
// flip period average that sets a slowdown percent.
// ----------------------------------------------------------------------------
// one item at a time; the next is taken the cycle after the result loads unless
//   it is stalled
// divisions by bandwidth or expected period use one 64-step restoring divider;
//   divisions by 10, 25 and 100 use a reciprocal multiply, 16 bits per chunk
// reset (rst, synchronous): registers to their reset values, state cleared
module storage_read_pacer_top
  import srp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  logic [TIME_W-1:0]       now_ns,
  input  logic [31:0]             byte_count,
  input  logic signed [31:0]      expected_period_ns,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [TIME_W-1:0]       deadline_ns,
  output logic [PCT_W-1:0]        slowdown_pct
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_BYTES, S_DIV, S_CDIV_MUL, S_CDIV_SUB, S_MUL_PCT, S_ADD,
    S_AVG, S_AVG_WB, S_PCT, S_CLAMP, S_ROUND, S_DONE
  } state_t;

  state_t state, div_ret;

  // configuration registers
  logic                 enabled;
  logic [14:0]          bandwidth;
  logic                 bypass;
  logic [29:0]          burst;
  logic [31:0]          flip_gap;

  // pacing state
  logic [TIME_W-1:0]    cursor;
  logic [PCT_W-1:0]     slowdown;
  logic [TIME_W-1:0]    last_flip;
  logic                 flip_seen;
  logic [31:0]          avg;

  // per item operands
  logic [31:0]          op_a;      // byte count of a read, period of a flip
  logic [30:0]          expected;

  // shared divider: div_q holds the dividend, shifts in quotient bits
  logic [63:0]          div_q;
  logic [30:0]          div_r;
  logic [30:0]          div_d;
  logic [5:0]           div_cnt;

  // constant divider: reciprocal and registered product of one 16-bit chunk
  logic [26:0]          recip;
  logic [45:0]          cd_prod;
  logic [22:0]          cd_t, cd_rem;
  logic [15:0]          cd_qc;

  logic                 in_accept, cfg_write;
  logic [31:0]          rem_sh, rem_next;
  logic                 fits;
  logic [TIME_W-1:0]    floor_ns, cursor_next, flip_diff;
  logic                 flip_restart;
  logic [61:0]          mul_bytes;
  logic [50:0]          mul_pct;
  logic [PCT_W-1:0]     pct_sel, pct_clamped, round_pct;
  logic [35:0]          avg_mix;
  logic [38:0]          avg_pct;
  logic [63:0]          sum;
  logic [14:0]          bw_eff;

  // a pending register write holds off new items
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;

  // one restoring step
  assign rem_sh   = {div_r, div_q[63]};
  assign fits     = rem_sh >= {1'b0, div_d};
  assign rem_next = fits ? (rem_sh - {1'b0, div_d}) : rem_sh;

  // one constant division chunk: remainder so far above the next 16 bits
  assign cd_t   = {div_r[6:0], div_q[63:48]};
  assign cd_qc  = cd_prod[RECIP_SHIFT +: 16];
  assign cd_rem = cd_t - 23'(cd_qc) * 23'(div_d[6:0]);

  // cursor lag floor, now minus burst, clipped at zero
  assign floor_ns    = (now_ns >= TIME_W'(burst)) ? (now_ns - TIME_W'(burst)) : '0;
  assign cursor_next = (cursor < floor_ns) ? floor_ns : cursor;

  // flip gap check
  assign flip_diff    = now_ns - last_flip;
  assign flip_restart = !flip_seen || (now_ns < last_flip) ||
                        (flip_diff > TIME_W'(flip_gap));

  // bytes * 1e9 / 2^20 feeds the division by bandwidth
  assign mul_bytes = 62'(op_a) * 62'(NS_PER_S);
  assign bw_eff    = (bandwidth == '0) ? 15'd1 : bandwidth;
  assign pct_sel   = bypass ? PCT_UNITY : slowdown;
  assign mul_pct   = 51'(div_q[41:0]) * 51'(pct_sel);
  assign sum       = {1'b0, cursor} + div_q;

  // 9:1 average and percent scaling through shifts and adds
  assign avg_mix = (36'(avg) << 3) + 36'(avg) + 36'(op_a);
  assign avg_pct = (39'(avg) << 6) + (39'(avg) << 5) + (39'(avg) << 2);

  always_comb begin
    if (div_q < 64'(PCT_UNITY)) begin
      pct_clamped = PCT_UNITY;
    end else if (div_q > 64'(PCT_MAX)) begin
      pct_clamped = PCT_MAX;
    end else begin
      pct_clamped = div_q[PCT_W-1:0];
    end
  end

  // quotient of the step division times 25
  assign round_pct = (9'(div_q[4:0]) << 4) + (9'(div_q[4:0]) << 3) + 9'(div_q[4:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      div_ret     <= S_IDLE;
      enabled     <= 1'b0;
      bandwidth   <= BANDWIDTH_RST;
      bypass      <= 1'b0;
      burst       <= BURST_RST;
      flip_gap    <= FLIP_GAP_RST;
      cursor      <= '0;
      slowdown    <= PCT_UNITY;
      last_flip   <= '0;
      flip_seen   <= 1'b0;
      avg         <= '0;
      out_valid   <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (!command) begin
              // read: pull cursor up to the lag floor first
              cursor <= cursor_next;
              op_a   <= byte_count;
              if (!enabled || byte_count == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_MUL_BYTES;
              end
            end else if (!enabled || expected_period_ns <= 0) begin
              state <= S_DONE;
            end else if (flip_restart) begin
              // first flip, long gap or time going backwards
              flip_seen <= 1'b1;
              last_flip <= now_ns;
              avg       <= '0;
              slowdown  <= PCT_UNITY;
              state     <= S_DONE;
            end else begin
              last_flip <= now_ns;
              op_a      <= flip_diff[31:0];
              expected  <= expected_period_ns[30:0];
              state     <= S_AVG;
            end
          end
        end
        S_MUL_BYTES: begin
          div_q   <= 64'(mul_bytes >> MIB_SHIFT);
          div_d   <= 31'(bw_eff);
          div_r   <= '0;
          div_cnt <= '1;
          div_ret <= S_MUL_PCT;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_q   <= {div_q[62:0], fits};
          div_r   <= rem_next[30:0];
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == '0) begin
            state <= div_ret;
          end
        end
        S_CDIV_MUL: begin
          cd_prod <= 46'(50'(cd_t) * 50'(recip));
          state   <= S_CDIV_SUB;
        end
        S_CDIV_SUB: begin
          div_q   <= {div_q[47:0], cd_qc};
          div_r   <= 31'(cd_rem[6:0]);
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == '0) begin
            state <= div_ret;
          end else begin
            state <= S_CDIV_MUL;
          end
        end
        S_MUL_PCT: begin
          div_q   <= 64'(mul_pct);
          div_d   <= PCT_DIV;
          recip   <= RECIP_100;
          div_r   <= '0;
          div_cnt <= 6'd3;
          div_ret <= S_ADD;
          state   <= S_CDIV_MUL;
        end
        S_ADD: begin
          // saturate at the top of the time range
          cursor <= sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          state  <= S_DONE;
        end
        S_AVG: begin
          if (avg == '0) begin
            avg   <= op_a;
            state <= S_PCT;
          end else begin
            div_q   <= 64'(avg_mix);
            div_d   <= AVG_DIV;
            recip   <= RECIP_10;
            div_r   <= '0;
            div_cnt <= 6'd3;
            div_ret <= S_AVG_WB;
            state   <= S_CDIV_MUL;
          end
        end
        S_AVG_WB: begin
          avg   <= div_q[31:0];
          state <= S_PCT;
        end
        S_PCT: begin
          div_q   <= 64'(avg_pct);
          div_d   <= expected;
          div_r   <= '0;
          div_cnt <= '1;
          div_ret <= S_CLAMP;
          state   <= S_DIV;
        end
        S_CLAMP: begin
          div_q   <= 64'(pct_clamped + ROUND_BIAS);
          div_d   <= ROUND_STEP;
          recip   <= RECIP_25;
          div_r   <= '0;
          div_cnt <= 6'd3;
          div_ret <= S_ROUND;
          state   <= S_CDIV_MUL;
        end
        S_ROUND: begin
          slowdown <= round_pct;
          state    <= S_DONE;
        end
        S_DONE: begin
          // output register free or being emptied this cycle
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            deadline_ns  <= cursor;
            slowdown_pct <= slowdown;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLED:   enabled   <= cfg_data[0];
          REG_BANDWIDTH: bandwidth <= cfg_data[14:0];
          REG_BYPASS:    bypass    <= cfg_data[0];
          REG_BURST:     burst     <= cfg_data[29:0];
          REG_FLIP_GAP:  flip_gap  <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_FLIP_GAP) begin
          cursor    <= '0;
          slowdown  <= PCT_UNITY;
          last_flip <= '0;
          flip_seen <= 1'b0;
          avg       <= '0;
        end
      end
    end
  end

  // slowdown stays in its clamped range
  a_slowdown_range: assert property (@(posedge clk) disable iff (rst)
    slowdown >= PCT_UNITY && slowdown <= PCT_MAX)
    else $error("slowdown out of range");

  // divider never runs against a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_d != '0)
    else $error("division by zero");

  // divider keeps running until its count is spent
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && div_cnt != '0 |=> state == S_DIV)
    else $error("divider left early");

  // constant division keeps its remainder below the divisor
  a_cdiv_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_CDIV_MUL |-> div_r < div_d)
    else $error("constant division remainder too large");

  // a result is only loaded out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result without finished item");

endmodule
